FILE: hw/rtl/mrtd_pkg.sv
// Shared types and constants for the map/reduce task dispatcher.
// Holds the status codes, request codes, cell control structs and count helpers.
// No dependencies.
package mrtd_pkg;

	localparam int MAX_MAP_TASKS    = 64;
	localparam int MAX_REDUCE_TASKS = 16;
	localparam int MAX_WORKERS      = 16;

	localparam int TASK_W  = 6;   // task index width
	localparam int MCNT_W  = 7;   // map count, 1..64
	localparam int RCNT_W  = 5;   // reduce count, 1..16
	localparam int WID_W   = 4;   // worker id width
	localparam int WCNT_W  = 5;   // next worker id, 0..16
	localparam int TIMER_W = 8;
	localparam int CFG_W   = 8;
	localparam int CIDX_W  = 2;

	localparam logic [TIMER_W-1:0] TIMER_MAX     = 8'hFF;
	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 8'd8;

	localparam logic [CIDX_W-1:0] CFG_MAP_COUNT    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_REDUCE_COUNT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_TIMEOUT      = 2'd2;

	typedef enum logic [1:0] {
		ST_UNASSIGNED = 2'd0,
		ST_RUNNING    = 2'd1,
		ST_FINISHED   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		W_FREE    = 2'd0,
		W_BUSY    = 2'd1,
		W_TIMEOUT = 2'd2
	} wstate_t;

	typedef enum logic [1:0] {
		MODE_ASK    = 2'd0,
		MODE_REPORT = 2'd1,
		MODE_TICK   = 2'd2,
		MODE_HEALTH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_MAP    = 2'd1,
		KIND_REDUCE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		WOP_NONE   = 2'd0,
		WOP_FREE   = 2'd1,
		WOP_ASSIGN = 2'd2
	} wop_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_PREP   = 3'd1,
		S_SEARCH = 3'd2,
		S_SWEEP  = 3'd3,
		S_FIN    = 3'd4
	} fsm_t;

	typedef struct packed {
		logic              clr;
		logic              srch_en;
		logic              srch_red;
		logic              stop;
		logic              wr_en;
		logic              wr_red;
		logic [TASK_W-1:0] wr_idx;
		status_t           wr_val;
	} task_ctl_t;

	typedef struct packed {
		logic               clr;
		wop_t               op;
		logic [WID_W-1:0]   id;
		logic [TASK_W-1:0]  tsk;
		logic               sw_en;
		logic [TIMER_W-1:0] timeout;
		logic [WID_W-1:0]   rd_id;
	} wrk_ctl_t;

	// zero acts as one, above the maximum acts as the maximum
	function automatic logic [MCNT_W-1:0] eff_map(input logic [MCNT_W-1:0] v);
		logic [MCNT_W-1:0] r;
		r = v;
		if (v == '0) r = MCNT_W'(1);
		else if (v > MCNT_W'(MAX_MAP_TASKS)) r = MCNT_W'(MAX_MAP_TASKS);
		return r;
	endfunction

	function automatic logic [RCNT_W-1:0] eff_red(input logic [RCNT_W-1:0] v);
		logic [RCNT_W-1:0] r;
		r = v;
		if (v == '0) r = RCNT_W'(1);
		else if (v > RCNT_W'(MAX_REDUCE_TASKS)) r = RCNT_W'(MAX_REDUCE_TASKS);
		return r;
	endfunction

endpackage

FILE: hw/rtl/mrtd_task_cell.sv
// One task slot: map and reduce status for one task number.
// A search token passes from cell to cell; the first unassigned slot claims it.
// Depends on mrtd_pkg.
module mrtd_task_cell import mrtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TASK_W-1:0] idx,
	input  task_ctl_t         ctl,
	input  logic              tok_in,
	output logic              tok_out,
	output logic              hit
);

	status_t map_st_q;
	status_t red_st_q;
	logic    tok_q;
	status_t cur;

	assign cur     = ctl.srch_red ? red_st_q : map_st_q;
	assign hit     = tok_q & ctl.srch_en & (cur == ST_UNASSIGNED);
	assign tok_out = tok_q & ctl.srch_en & ~ctl.stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_st_q <= ST_UNASSIGNED;
			red_st_q <= ST_UNASSIGNED;
			tok_q    <= 1'b0;
		end else if (ctl.clr) begin
			map_st_q <= ST_UNASSIGNED;
			red_st_q <= ST_UNASSIGNED;
			tok_q    <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (ctl.wr_en && ctl.wr_idx == idx) begin
				if (ctl.wr_red) red_st_q <= ctl.wr_val;
				else map_st_q <= ctl.wr_val;
			end
			if (hit) begin
				if (ctl.srch_red) red_st_q <= ST_RUNNING;
				else map_st_q <= ST_RUNNING;
			end
		end
	end

endmodule

FILE: hw/rtl/mrtd_worker_cell.sv
// One worker slot: state, saturating tick timer, active bit and held task.
// A sweep token passes from cell to cell, one worker per cycle.
// Depends on mrtd_pkg.
module mrtd_worker_cell import mrtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WID_W-1:0]  idx,
	input  wrk_ctl_t          ctl,
	input  logic              tok_in,
	output logic              tok_out,
	output logic              rq,
	output logic [TASK_W-1:0] rq_task,
	output logic              timed_out
);

	wstate_t            st_q;
	logic [TIMER_W-1:0] timer_q;
	logic               active_q;
	logic [TASK_W-1:0]  task_q;
	logic               tok_q;
	logic               visit;
	logic               expire;

	assign visit     = tok_q & ctl.sw_en & active_q;
	assign expire    = visit & (st_q == W_BUSY) & (timer_q >= ctl.timeout);
	assign rq        = expire;
	assign rq_task   = expire ? task_q : '0;
	assign tok_out   = tok_q & ctl.sw_en;
	assign timed_out = (ctl.rd_id == idx) & (st_q == W_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= W_FREE;
			timer_q  <= '0;
			active_q <= 1'b0;
			tok_q    <= 1'b0;
		end else if (ctl.clr) begin
			st_q     <= W_FREE;
			timer_q  <= '0;
			active_q <= 1'b0;
			tok_q    <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (ctl.id == idx) begin
				case (ctl.op)
					WOP_FREE: begin
						st_q <= W_FREE;
					end
					WOP_ASSIGN: begin
						st_q     <= W_BUSY;
						timer_q  <= '0;
						active_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (expire) st_q <= W_TIMEOUT;
			else if (visit && timer_q != TIMER_MAX) timer_q <= timer_q + 1'b1;
		end
	end

	// task number needs no reset: read only after an assign
	always_ff @(posedge clk) begin
		if (ctl.op == WOP_ASSIGN && ctl.id == idx) task_q <= ctl.tsk;
	end

endmodule

FILE: hw/rtl/map_reduce_task_dispatcher.sv
// Map/reduce task dispatcher: one result beat per request beat.
// Ask scans the task cells in order, one task cell per cycle, up to 64 (the phase's count).
// Tick sweeps all 16 worker cells, one per cycle; report and health skip the scans.
// One request in flight at a time; a new request is taken once the result is queued.
// arst_n clears all status, worker and phase state; counts reset to 1, timeout to 8.
// Depends on mrtd_pkg, mrtd_task_cell and mrtd_worker_cell.
module map_reduce_task_dispatcher import mrtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic              new_worker,
	input  logic [WID_W-1:0]  req_worker,
	input  logic [TASK_W-1:0] task_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WID_W-1:0]  assigned_worker,
	output logic              has_task,
	output logic [1:0]        task_kind,
	output logic [TASK_W-1:0] task_number,
	output logic              worker_ok,
	output logic              all_done,
	output logic              id_overflow
);

	fsm_t state_q, state_nx;

	logic [MCNT_W-1:0]  map_n_q;
	logic [RCNT_W-1:0]  red_n_q;
	logic [TIMER_W-1:0] timeout_q;
	logic [WCNT_W-1:0]  next_worker_q;
	logic [MCNT_W-1:0]  maps_left_q;
	logic [RCNT_W-1:0]  reduces_left_q;
	logic               map_done_q;
	logic               red_done_q;

	mode_t              mode_q;
	logic               nw_q;
	logic [WID_W-1:0]   wid_q;
	logic [TASK_W-1:0]  tix_q;
	logic [WID_W-1:0]   id_q;
	kind_t              kind_q;
	logic [TASK_W-1:0]  cnt_q;
	logic [WID_W-1:0]   wcnt_q;

	logic [WID_W-1:0]   res_worker_q;
	logic               res_has_q;
	kind_t              res_kind_q;
	logic [TASK_W-1:0]  res_num_q;
	logic               res_ok_q;
	logic               res_done_q;
	logic               res_ovf_q;

	logic               out_valid_q;
	logic [WID_W-1:0]   out_worker_q;
	logic               out_has_q;
	kind_t              out_kind_q;
	logic [TASK_W-1:0]  out_num_q;
	logic               out_ok_q;
	logic               out_done_q;
	logic               out_ovf_q;

	task_ctl_t tctl;
	wrk_ctl_t  wctl;

	logic [MAX_MAP_TASKS-1:0] hit_vec;
	logic [MAX_MAP_TASKS-1:0] ttok;
	logic [MAX_WORKERS-1:0]   wtok;
	logic [MAX_WORKERS-1:0]   rq_vec;
	logic [MAX_WORKERS-1:0]   to_vec;
	logic [TASK_W-1:0]        rq_task_vec [MAX_WORKERS];

	logic              hit_any;
	logic              rq_any;
	logic [TASK_W-1:0] rq_task;
	logic              to_any;
	logic              accept;
	logic              out_free;
	logic              cfg_clr;
	logic              id_ok;
	logic [WID_W-1:0]  id_now;
	kind_t             kind_now;
	logic [TASK_W-1:0] n_last;
	logic              scan_end;
	logic              rep_map;
	logic              rep_red;
	logic [MCNT_W-1:0] ml_dec;
	logic [RCNT_W-1:0] rl_dec;
	logic              rq_map;
	logic              rq_red;
	logic              tstart;
	logic              wstart;
	logic [MCNT_W-1:0] cfg_map_eff;
	logic [RCNT_W-1:0] cfg_red_eff;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = ~out_valid_q | ~out_stall;
	assign cfg_clr  = cfg_we & (cfg_index == CFG_MAP_COUNT || cfg_index == CFG_REDUCE_COUNT);

	assign cfg_map_eff = eff_map(cfg_data[MCNT_W-1:0]);
	assign cfg_red_eff = eff_red(cfg_data[RCNT_W-1:0]);

	assign hit_any = |hit_vec;
	assign to_any  = |to_vec;

	always_comb begin
		rq_task = '0;
		for (int i = 0; i < MAX_WORKERS; i++) rq_task = rq_task | rq_task_vec[i];
	end
	assign rq_any = |rq_vec;

	assign id_ok  = ~nw_q | (next_worker_q < WCNT_W'(MAX_WORKERS));
	assign id_now = nw_q ? (id_ok ? next_worker_q[WID_W-1:0] : '0) : wid_q;

	always_comb begin
		if (!map_done_q) kind_now = KIND_MAP;
		else if (!red_done_q) kind_now = KIND_REDUCE;
		else kind_now = KIND_NONE;
	end

	assign n_last   = (kind_q == KIND_REDUCE) ? TASK_W'(MCNT_W'(red_n_q) - 1'b1)
	                                          : TASK_W'(map_n_q - 1'b1);
	assign scan_end = hit_any | (cnt_q == n_last);

	assign rep_map = ~map_done_q & ({1'b0, tix_q} < map_n_q);
	assign rep_red = map_done_q & ~red_done_q & (tix_q < TASK_W'(red_n_q));
	assign ml_dec  = maps_left_q - MCNT_W'(maps_left_q != '0);
	assign rl_dec  = reduces_left_q - RCNT_W'(reduces_left_q != '0);
	assign rq_map  = ~map_done_q & ({1'b0, rq_task} < map_n_q);
	assign rq_red  = map_done_q & ~red_done_q & (rq_task < TASK_W'(red_n_q));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_PREP;
			end
			S_PREP: begin
				case (mode_q)
					MODE_ASK: begin
						if (id_ok && kind_now != KIND_NONE) state_nx = S_SEARCH;
						else state_nx = S_FIN;
					end
					MODE_TICK: state_nx = S_SWEEP;
					default:   state_nx = S_FIN;
				endcase
			end
			S_SEARCH: begin
				if (scan_end) state_nx = S_FIN;
			end
			S_SWEEP: begin
				if (wcnt_q == WID_W'(MAX_WORKERS - 1)) state_nx = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// cell controls
	always_comb begin
		tctl          = '0;
		tctl.clr      = cfg_clr;
		tctl.srch_en  = (state_q == S_SEARCH);
		tctl.srch_red = (kind_q == KIND_REDUCE);
		tctl.stop     = (state_q == S_SEARCH) & scan_end;
		tctl.wr_val   = ST_FINISHED;
		tctl.wr_idx   = tix_q;
		wctl          = '0;
		wctl.clr      = cfg_clr;
		wctl.op       = WOP_NONE;
		wctl.timeout  = timeout_q;
		wctl.rd_id    = wid_q;
		wctl.sw_en    = (state_q == S_SWEEP);
		wctl.id       = id_q;
		wctl.tsk      = cnt_q;
		tstart        = 1'b0;
		wstart        = 1'b0;
		case (state_q)
			S_PREP: begin
				case (mode_q)
					MODE_ASK: begin
						tstart = id_ok & (kind_now != KIND_NONE);
						if (nw_q && id_ok) begin
							wctl.op = WOP_FREE;
							wctl.id = id_now;
						end
					end
					MODE_REPORT: begin
						if (rep_map || rep_red) begin
							tctl.wr_en  = 1'b1;
							tctl.wr_red = rep_red;
							wctl.op     = WOP_FREE;
							wctl.id     = wid_q;
						end
					end
					MODE_TICK: wstart = 1'b1;
					default: begin
					end
				endcase
			end
			S_SEARCH: begin
				if (hit_any) wctl.op = WOP_ASSIGN;
			end
			S_SWEEP: begin
				// requeue the task of a worker that just timed out
				if (rq_any && (rq_map || rq_red)) begin
					tctl.wr_en  = 1'b1;
					tctl.wr_red = rq_red;
					tctl.wr_idx = rq_task;
					tctl.wr_val = ST_UNASSIGNED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			map_n_q        <= MCNT_W'(1);
			red_n_q        <= RCNT_W'(1);
			timeout_q      <= TIMEOUT_RESET;
			next_worker_q  <= '0;
			maps_left_q    <= MCNT_W'(1);
			reduces_left_q <= RCNT_W'(1);
			map_done_q     <= 1'b0;
			red_done_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAP_COUNT: begin
						map_n_q        <= cfg_map_eff;
						maps_left_q    <= cfg_map_eff;
						reduces_left_q <= red_n_q;
						next_worker_q  <= '0;
						map_done_q     <= 1'b0;
						red_done_q     <= 1'b0;
					end
					CFG_REDUCE_COUNT: begin
						red_n_q        <= cfg_red_eff;
						reduces_left_q <= cfg_red_eff;
						maps_left_q    <= map_n_q;
						next_worker_q  <= '0;
						map_done_q     <= 1'b0;
						red_done_q     <= 1'b0;
					end
					CFG_TIMEOUT: timeout_q <= cfg_data[TIMER_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_PREP) begin
				if (mode_q == MODE_ASK && nw_q && id_ok) next_worker_q <= next_worker_q + 1'b1;
				if (mode_q == MODE_REPORT && rep_map) begin
					maps_left_q <= ml_dec;
					if (ml_dec == '0) map_done_q <= 1'b1;
				end
				if (mode_q == MODE_REPORT && rep_red) begin
					reduces_left_q <= rl_dec;
					if (rl_dec == '0) red_done_q <= 1'b1;
				end
			end
			if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			nw_q   <= new_worker;
			wid_q  <= req_worker;
			tix_q  <= task_index;
		end
		case (state_q)
			S_PREP: begin
				id_q         <= id_now;
				kind_q       <= kind_now;
				cnt_q        <= '0;
				wcnt_q       <= '0;
				res_has_q    <= 1'b0;
				res_num_q    <= '0;
				res_worker_q <= (mode_q == MODE_TICK) ? '0 : ((mode_q == MODE_ASK) ? id_now : wid_q);
				res_kind_q   <= (mode_q == MODE_ASK) ? kind_now : KIND_NONE;
				res_ok_q     <= (mode_q == MODE_HEALTH) & ~to_any;
				res_done_q   <= (mode_q == MODE_TICK) & map_done_q & red_done_q;
				res_ovf_q    <= (mode_q == MODE_ASK) & nw_q & ~id_ok;
			end
			S_SEARCH: begin
				if (hit_any) begin
					res_has_q <= 1'b1;
					res_num_q <= cnt_q;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_SWEEP: wcnt_q <= wcnt_q + 1'b1;
			default: begin
			end
		endcase
		if (state_q == S_FIN && out_free) begin
			out_worker_q <= res_worker_q;
			out_has_q    <= res_has_q;
			out_kind_q   <= res_kind_q;
			out_num_q    <= res_num_q;
			out_ok_q     <= res_ok_q;
			out_done_q   <= res_done_q;
			out_ovf_q    <= res_ovf_q;
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_MAP_TASKS; g++) begin : g_task
			logic tin;
			if (g == 0) begin : g_head
				assign tin = tstart;
			end else begin : g_link
				assign tin = ttok[g-1];
			end
			mrtd_task_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (TASK_W'(g)),
				.ctl     (tctl),
				.tok_in  (tin),
				.tok_out (ttok[g]),
				.hit     (hit_vec[g])
			);
		end
		for (g = 0; g < MAX_WORKERS; g++) begin : g_wrk
			logic win;
			if (g == 0) begin : g_head
				assign win = wstart;
			end else begin : g_link
				assign win = wtok[g-1];
			end
			mrtd_worker_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.idx       (WID_W'(g)),
				.ctl       (wctl),
				.tok_in    (win),
				.tok_out   (wtok[g]),
				.rq        (rq_vec[g]),
				.rq_task   (rq_task_vec[g]),
				.timed_out (to_vec[g])
			);
		end
	endgenerate

	assign out_valid       = out_valid_q;
	assign assigned_worker = out_worker_q;
	assign has_task        = out_has_q;
	assign task_kind       = out_kind_q;
	assign task_number     = out_num_q;
	assign worker_ok       = out_ok_q;
	assign all_done        = out_done_q;
	assign id_overflow     = out_ovf_q;

endmodule

FILE: hw/rtl/mrtd_checker.sv
// Port-level checks for the task dispatcher, bound to the top level.
// Depends on mrtd_pkg and map_reduce_task_dispatcher.
module mrtd_checker import mrtd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WID_W-1:0]  assigned_worker,
	input logic              has_task,
	input logic [1:0]        task_kind,
	input logic              all_done,
	input logic              id_overflow
);

	// one request in flight: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in flight");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared one cycle after request");

	a_task_has_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_task |-> task_kind != KIND_NONE && !id_overflow)
		else $error("task given without phase or with id overflow");

	a_done_no_task: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_done |-> !has_task && task_kind == KIND_NONE)
		else $error("done flag mixed with task result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(assigned_worker))
		else $error("stalled result beat changed");

endmodule

bind map_reduce_task_dispatcher mrtd_checker u_mrtd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.assigned_worker (assigned_worker),
	.has_task        (has_task),
	.task_kind       (task_kind),
	.all_done        (all_done),
	.id_overflow     (id_overflow)
);
